FILE: rtl/core/scs_pkg.sv
// shared types, register codes and helpers for the sphere contact force pipeline
`timescale 1ns / 1ps
package scs_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_CENTER_X   = 3'd0;
   localparam logic [2:0] REG_CENTER_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_Z   = 3'd2;
   localparam logic [2:0] REG_RADIUS     = 3'd3;
   localparam logic [2:0] REG_STIFFNESS  = 3'd4;
   localparam logic [2:0] REG_DAMP_LIN   = 3'd5;
   localparam logic [2:0] REG_DAMP_ANG   = 3'd6;

   // register reset values (center z is -78643 in two's complement)
   localparam logic [21:0] RST_CENTER_X  = 22'd0;
   localparam logic [21:0] RST_CENTER_Y  = 22'd130023;
   localparam logic [21:0] RST_CENTER_Z  = 22'd4115661;
   localparam logic [20:0] RST_RADIUS    = 21'd52429;
   localparam logic [23:0] RST_STIFFNESS = 24'd128000;
   localparam logic [19:0] RST_DAMP_LIN  = 20'd20480;
   localparam logic [19:0] RST_DAMP_ANG  = 20'd410;

   // pipeline depths
   localparam int SQ_STEPS  = 31;
   localparam int DIV_STEPS = 32;

   // per item side information that travels beside the arithmetic
   typedef struct packed {
      logic             contact;
      logic             nz;
      logic [2:0]       neg;
      logic [2:0][20:0] dm;
      logic [2:0][26:0] nd;
      logic [1:0][23:0] tq;
   } scs_ctx_type;

   // clamp a signed value to the 24-bit output range
   function automatic logic [23:0] sat24(input logic signed [31:0] v);
      logic [23:0] r;
      if (v > 32'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -32'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/scs_front.sv
// front stages: offset, squares, damping terms, contact test and torque clamp
`timescale 1ns / 1ps
module scs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [2:0][21:0]    pos,
   input  logic [4:0][21:0]    rates,
   input  logic [2:0][21:0]    center,
   input  logic [20:0]         radius,
   input  logic [19:0]         damp_lin,
   input  logic [19:0]         damp_ang,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [41:0]         out_sq,
   output scs_pkg::scs_ctx_type out_ctx
);
   import scs_pkg::*;

   logic [3:0]       v_ff;
   logic             en;
   logic [2:0][22:0] dd;
   logic [2:0][21:0] dm1_in, dm1_ff;
   logic [2:0]       dn1_in, dn1_ff;
   logic [4:0][21:0] rm1_in, rm1_ff;
   logic [4:0]       rn1_in, rn1_ff;
   logic [2:0][43:0] sq2_in, sq2_ff;
   logic [4:0][41:0] dp2_in, dp2_ff;
   logic [41:0]      r22_in, r22_ff;
   logic [2:0][20:0] dm2_ff;
   logic [2:0]       dn2_ff;
   logic [4:0]       rn2_ff;
   logic [45:0]      s3_in, s3_ff;
   logic [4:0][26:0] nd3_in, nd3_ff;
   logic [25:0]      rmag;
   logic [41:0]      r23_ff;
   logic [2:0][20:0] dm3_ff;
   logic [2:0]       dn3_ff;
   scs_ctx_type      ctx4_in, ctx4_ff;
   logic [41:0]      sq4_ff;

   // whole front moves together
   assign en        = !v_ff[3] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[3];
   assign out_sq    = sq4_ff;
   assign out_ctx   = ctx4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   // stage 1: offset from center and magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd[i]     = {pos[i][21], pos[i]} - {center[i][21], center[i]};
         dn1_in[i] = dd[i][22];
         dm1_in[i] = dd[i][22] ? 22'(~dd[i] + 23'd1) : dd[i][21:0];
      end
      for (int j = 0; j < 5; j++) begin
         rn1_in[j] = rates[j][21];
         rm1_in[j] = rates[j][21] ? (~rates[j] + 22'd1) : rates[j];
      end
   end

   // stage 2: squares and gain products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq2_in[i] = 44'(dm1_ff[i]) * 44'(dm1_ff[i]);
      end
      for (int j = 0; j < 5; j++) begin
         dp2_in[j] = (j < 3) ? 42'(damp_lin) * 42'(rm1_ff[j])
                             : 42'(damp_ang) * 42'(rm1_ff[j]);
      end
      r22_in = 42'(radius) * 42'(radius);
   end

   // stage 3: squared length and rounded negated damping
   always_comb begin
      rmag  = '0;
      s3_in = 46'(sq2_ff[0]) + 46'(sq2_ff[1]) + 46'(sq2_ff[2]);
      for (int j = 0; j < 5; j++) begin
         rmag      = 26'((dp2_ff[j] + 42'h8000) >> 16);
         nd3_in[j] = rn2_ff[j] ? {1'b0, rmag} : 27'd0 - {1'b0, rmag};
      end
   end

   // stage 4: contact test and torque clamp
   always_comb begin
      ctx4_in.contact = s3_ff < {4'd0, r23_ff};
      ctx4_in.nz      = s3_ff != 46'd0;
      ctx4_in.neg     = dn3_ff;
      ctx4_in.dm      = dm3_ff;
      for (int i = 0; i < 3; i++) begin
         ctx4_in.nd[i] = nd3_ff[i];
      end
      for (int j = 0; j < 2; j++) begin
         ctx4_in.tq[j] = sat24($signed({{5{nd3_ff[3 + j][26]}}, nd3_ff[3 + j]}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm1_ff <= dm1_in;
         dn1_ff <= dn1_in;
         rm1_ff <= rm1_in;
         rn1_ff <= rn1_in;
         sq2_ff <= sq2_in;
         dp2_ff <= dp2_in;
         r22_ff <= r22_in;
         for (int i = 0; i < 3; i++) begin
            dm2_ff[i] <= dm1_ff[i][20:0];
         end
         dn2_ff  <= dn1_ff;
         rn2_ff  <= rn1_ff;
         s3_ff   <= s3_in;
         nd3_ff  <= nd3_in;
         r23_ff  <= r22_ff;
         dm3_ff  <= dm2_ff;
         dn3_ff  <= dn2_ff;
         ctx4_ff <= ctx4_in;
         sq4_ff  <= s3_ff[41:0];
      end
   end

endmodule

FILE: rtl/core/scs_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module scs_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [41:0]          in_sq,
   input  scs_pkg::scs_ctx_type in_ctx,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [30:0]          out_len,
   output scs_pkg::scs_ctx_type out_ctx
);
   import scs_pkg::*;

   logic [SQ_STEPS-1:0] v_ff;
   logic                en;
   logic [32:0]         rem_in  [SQ_STEPS];
   logic [32:0]         rem_ff  [SQ_STEPS];
   logic [30:0]         root_in [SQ_STEPS];
   logic [30:0]         root_ff [SQ_STEPS];
   logic [61:0]         xs_in   [SQ_STEPS];
   logic [61:0]         xs_ff   [SQ_STEPS];
   scs_ctx_type         ctx_ff  [SQ_STEPS];

   assign en        = !v_ff[SQ_STEPS-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[SQ_STEPS-1];
   assign out_len   = root_ff[SQ_STEPS-1];
   assign out_ctx   = ctx_ff[SQ_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[SQ_STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [32:0] rem_p;
      logic [30:0] root_p;
      logic [61:0] xs_p;
      scs_ctx_type ctx_p;
      logic [34:0] rsh;
      logic [34:0] trl;
      logic        ge;

      // operand is the squared length scaled by 2^20
      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign xs_p   = {in_sq, 20'd0};
         assign ctx_p  = in_ctx;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign xs_p   = xs_ff[k-1];
         assign ctx_p  = ctx_ff[k-1];
      end

      // bring in two bits and try the next root bit
      always_comb begin
         rsh        = {rem_p, xs_p[61:60]};
         trl        = {2'b00, root_p, 2'b01};
         ge         = rsh >= trl;
         rem_in[k]  = ge ? 33'(rsh - trl) : rsh[32:0];
         root_in[k] = {root_p[29:0], ge};
         xs_in[k]   = {xs_p[59:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            xs_ff[k]   <= xs_in[k];
            ctx_ff[k]  <= ctx_p;
         end
      end
   end

endmodule

FILE: rtl/core/scs_div.sv
// depth, per-axis numerators and three pipelined restoring dividers
`timescale 1ns / 1ps
module scs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [30:0]          in_len,
   input  scs_pkg::scs_ctx_type in_ctx,
   input  logic [20:0]          radius,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0][31:0]     out_q,
   output scs_pkg::scs_ctx_type out_ctx
);
   import scs_pkg::*;

   localparam int NV = DIV_STEPS + 2;

   logic [NV-1:0]    v_ff;
   logic             en;
   logic [30:0]      pen_in, pen_ff;
   logic [30:0]      lena_ff;
   scs_ctx_type      ctxa_ff;
   logic [2:0][51:0] prod;
   logic [2:0][30:0] remb_in, remb_ff;
   logic [2:0][31:0] bitb_in, bitb_ff;
   logic [30:0]      lenb_ff;
   scs_ctx_type      ctxb_ff;
   logic [2:0][30:0] drem_in [DIV_STEPS];
   logic [2:0][30:0] drem_ff [DIV_STEPS];
   logic [2:0][31:0] dbit_in [DIV_STEPS];
   logic [2:0][31:0] dbit_ff [DIV_STEPS];
   logic [2:0][31:0] dq_in   [DIV_STEPS];
   logic [2:0][31:0] dq_ff   [DIV_STEPS];
   logic [30:0]      dlen_ff [DIV_STEPS];
   scs_ctx_type      dctx_ff [DIV_STEPS];

   assign en        = !v_ff[NV-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[NV-1];
   assign out_q     = dq_ff[DIV_STEPS-1];
   assign out_ctx   = dctx_ff[DIV_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NV-2:0], in_valid};
      end
   end

   // penetration depth in 2^-30 m
   assign pen_in = {radius, 10'd0} - in_len;

   // numerator |d| * depth * 2^10, split into preloaded remainder and shift bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]    = 52'(ctxa_ff.dm[i]) * 52'(pen_ff);
         remb_in[i] = {1'b0, prod[i][51:22]};
         bitb_in[i] = {prod[i][21:0], 10'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pen_ff  <= pen_in;
         lena_ff <= in_len;
         ctxa_ff <= in_ctx;
         remb_ff <= remb_in;
         bitb_ff <= bitb_in;
         lenb_ff <= lena_ff;
         ctxb_ff <= ctxa_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [2:0][30:0] rem_p;
      logic [2:0][31:0] bit_p;
      logic [2:0][31:0] q_p;
      logic [30:0]      len_p;
      scs_ctx_type      ctx_p;
      logic [31:0]      rs;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_p = remb_ff;
         assign bit_p = bitb_ff;
         assign q_p   = '0;
         assign len_p = lenb_ff;
         assign ctx_p = ctxb_ff;
      end else begin : g_next
         assign rem_p = drem_ff[k-1];
         assign bit_p = dbit_ff[k-1];
         assign q_p   = dq_ff[k-1];
         assign len_p = dlen_ff[k-1];
         assign ctx_p = dctx_ff[k-1];
      end

      // one quotient bit per lane
      always_comb begin
         rs = '0;
         ge = 1'b0;
         for (int i = 0; i < 3; i++) begin
            rs            = {rem_p[i], bit_p[i][31]};
            ge            = rs >= {1'b0, len_p};
            drem_in[k][i] = ge ? 31'(rs - {1'b0, len_p}) : rs[30:0];
            dq_in[k][i]   = {q_p[i][30:0], ge};
            dbit_in[k][i] = {bit_p[i][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k] <= drem_in[k];
            dbit_ff[k] <= dbit_in[k];
            dq_ff[k]   <= dq_in[k];
            dlen_ff[k] <= len_p;
            dctx_ff[k] <= ctx_p;
         end
      end
   end

endmodule

FILE: rtl/core/scs_back.sv
// back stages: spring force, rounding, damping sum and output clamp
`timescale 1ns / 1ps
module scs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2:0][31:0]     in_q,
   input  scs_pkg::scs_ctx_type in_ctx,
   input  logic [23:0]          stiffness,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [2:0][23:0]     force_o,
   output logic [1:0][23:0]     torque_o,
   output logic                 contact_o
);
   import scs_pkg::*;

   logic [2:0]       v_ff;
   logic             en;
   logic [2:0][55:0] prod_in, prod_ff;
   scs_ctx_type      ctxm_ff;
   logic [2:0][29:0] smag;
   logic [2:0][30:0] spr_in, spr_ff;
   scs_ctx_type      ctxr_ff;
   logic [2:0][31:0] sum;
   logic [2:0][23:0] f_in, f_ff;
   logic [1:0][23:0] t_in, t_ff;
   logic             c_ff;

   assign en        = !v_ff[2] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[2];
   assign force_o   = f_ff;
   assign torque_o  = t_ff;
   assign contact_o = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // spring product, then round by 2^26 and apply the offset sign, or zero for a zero offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = 56'(stiffness) * 56'(in_q[i]);
         smag[i]    = 30'((prod_ff[i] + 56'h2000000) >> 26);
         if (!ctxm_ff.nz) begin
            spr_in[i] = '0;
         end else if (ctxm_ff.neg[i]) begin
            spr_in[i] = 31'd0 - {1'b0, smag[i]};
         end else begin
            spr_in[i] = {1'b0, smag[i]};
         end
      end
   end

   // add negated damping, clamp, zero everything outside the sphere
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i]  = {spr_ff[i][30], spr_ff[i]} + {{5{ctxr_ff.nd[i][26]}}, ctxr_ff.nd[i]};
         f_in[i] = ctxr_ff.contact ? sat24($signed(sum[i])) : 24'd0;
      end
      for (int j = 0; j < 2; j++) begin
         t_in[j] = ctxr_ff.contact ? ctxr_ff.tq[j] : 24'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         ctxm_ff <= in_ctx;
         spr_ff  <= spr_in;
         ctxr_ff <= ctxm_ff;
         f_ff    <= f_in;
         t_ff    <= t_in;
         c_ff    <= ctxr_ff.contact;
      end
   end

   // outside the sphere no force leaves the block
   a_no_force: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && !c_ff |-> f_ff == '0)
      else $error("force present without contact");

   a_no_torque: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && !c_ff |-> t_ff == '0)
      else $error("torque present without contact");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("pipeline holds items after reset");

endmodule

FILE: rtl/core/sphere_contact_force.sv
// top level: csr registers, stream ports and the pipeline chain
`timescale 1ns / 1ps
// Virtual sphere spring-damper. One item is taken every cycle unless stalled and each
// item gives one result (4 front, 31 square root, 2 depth and numerator, 32 divider and
// 3 output stages). The 31-step root of the squared offset and the 32-step per-axis
// division are most of the stages; a stall on rsp holds each block whose output stage
// holds an item; nothing is dropped or repeated. Registers are written through csr_we,
// csr_addr and csr_wdata and should only be changed while no transfer is in flight.
module sphere_contact_force (
   input  logic         clock,
   input  logic         reset,
   // pos_x, pos_y, pos_z, rate_x, rate_y, rate_z, rate_ang_a, rate_ang_b (22 bits each)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [175:0] req_tdata,
   // force_x, force_y, force_z, torque_a, torque_b (24 bits each), in_contact, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);
   import scs_pkg::*;

   logic [2:0][21:0] center_ff;
   logic [20:0]      radius_ff;
   logic [23:0]      stiff_ff;
   logic [19:0]      dlin_ff;
   logic [19:0]      dang_ff;
   logic [2:0][21:0] pos;
   logic [4:0][21:0] rates;
   logic             f_valid, f_ready;
   logic [41:0]      f_sq;
   scs_ctx_type      f_ctx;
   logic             s_valid, s_ready;
   logic [30:0]      s_len;
   scs_ctx_type      s_ctx;
   logic             d_valid, d_ready;
   logic [2:0][31:0] d_q;
   scs_ctx_type      d_ctx;
   logic [2:0][23:0] force_v;
   logic [1:0][23:0] torque_v;
   logic             contact_v;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= RST_CENTER_X;
         center_ff[1] <= RST_CENTER_Y;
         center_ff[2] <= RST_CENTER_Z;
         radius_ff    <= RST_RADIUS;
         stiff_ff     <= RST_STIFFNESS;
         dlin_ff      <= RST_DAMP_LIN;
         dang_ff      <= RST_DAMP_ANG;
      end else if (csr_we) begin
         case (csr_addr)
            REG_CENTER_X:  center_ff[0] <= csr_wdata[21:0];
            REG_CENTER_Y:  center_ff[1] <= csr_wdata[21:0];
            REG_CENTER_Z:  center_ff[2] <= csr_wdata[21:0];
            REG_RADIUS:    radius_ff    <= csr_wdata[20:0];
            REG_STIFFNESS: stiff_ff     <= csr_wdata;
            REG_DAMP_LIN:  dlin_ff      <= csr_wdata[19:0];
            REG_DAMP_ANG:  dang_ff      <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // unpack the request transfer
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = req_tdata[22*i +: 22];
      end
      for (int j = 0; j < 5; j++) begin
         rates[j] = req_tdata[66 + 22*j +: 22];
      end
   end

   scs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pos       (pos),
      .rates     (rates),
      .center    (center_ff),
      .radius    (radius_ff),
      .damp_lin  (dlin_ff),
      .damp_ang  (dang_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_sq    (f_sq),
      .out_ctx   (f_ctx)
   );

   scs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_sq     (f_sq),
      .in_ctx    (f_ctx),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_len   (s_len),
      .out_ctx   (s_ctx)
   );

   scs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_len    (s_len),
      .in_ctx    (s_ctx),
      .radius    (radius_ff),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_q     (d_q),
      .out_ctx   (d_ctx)
   );

   scs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_q      (d_q),
      .in_ctx    (d_ctx),
      .stiffness (stiff_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .force_o   (force_v),
      .torque_o  (torque_v),
      .contact_o (contact_v)
   );

   // pack the response transfer
   assign rsp_tdata = {7'd0, contact_v, torque_v[1], torque_v[0],
                       force_v[2], force_v[1], force_v[0]};

endmodule
